@@ src/mts_pkg.sv @@
package mts_pkg;

    localparam int WALK_WORDS_DEF = 32;
    localparam int PHASE_COUNT    = 6;

    localparam int ADDR_W  = 32;
    localparam int DATA_W  = 32;
    localparam int TOTAL_W = 25;
    localparam int CHUNK_W = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] PAT_AA = 32'hAAAA_AAAA;
    localparam logic [DATA_W-1:0] PAT_55 = 32'h5555_5555;
    localparam logic [DATA_W-1:0] PAT_FF = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] PAT_00 = 32'h0000_0000;

    localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'd270532608;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 25'd262144;
    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 17'd1024;

    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_STEP    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK = 2'd2;

    typedef enum logic [2:0] {
        PH_AA   = 3'd0,
        PH_55   = 3'd1,
        PH_FF   = 3'd2,
        PH_00   = 3'd3,
        PH_WALK = 3'd4,
        PH_ADDR = 3'd5
    } t_phase;

    typedef struct packed {
        logic              command;
        logic [DATA_W-1:0] read_data;
    } t_in;

    typedef struct packed {
        logic               req_valid;
        logic               req_write;
        logic [ADDR_W-1:0]  req_address;
        logic [DATA_W-1:0]  req_data;
        logic [DATA_W-1:0]  error_count;
        logic [TOTAL_W-1:0] words_done;
        logic               test_done;
    } t_out;

    typedef struct packed {
        logic [ADDR_W-1:0]  base_address;
        logic [TOTAL_W-1:0] total_words;
        logic [CHUNK_W-1:0] chunk_words;
    } t_cfg;

    typedef struct packed {
        t_phase             phase;
        logic               walk_zeros;
        logic               verify_pass;
        logic [CHUNK_W-1:0] word_index;
        logic [TOTAL_W-1:0] chunk_offset;
        logic [DATA_W-1:0]  mismatch_total;
        logic [DATA_W-1:0]  pending_expected;
        logic               pending_read;
    } t_state;

endpackage

@@ src/memory_test_sequencer.sv @@
// Memory self-test sequencer.
// Input channel (i_valid / o_ready, payload i_in): each beat is one step.
// command restart clears the test state and counters; command step issues
// the next memory request and checks read_data against the read issued on
// the previous step. Output channel (o_valid / i_ready, payload o_out):
// exactly one result beat per input beat, in order, carrying the request
// (if any), the saturating mismatch count, words done and test done.
// Configuration (i_cfg_we / i_cfg_index / i_cfg_data) sets base address,
// region size and chunk size; write it only while no beat is in flight.
// The input beat is held in the input register and the step result in the result
// register. Throughput: one step per cycle while the receiver does not stall, set
// by the single step of next-state logic between the two registers.
// Reset: test state clears, configuration returns to its defaults, both
// channels empty. A stalled receiver holds the result register; one more
// input beat is taken into the input register, then o_ready drops.
module memory_test_sequencer #(
    parameter int WALK_WORDS = mts_pkg::WALK_WORDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  mts_pkg::t_in                   i_in,
    output logic                           o_valid,
    input  logic                           i_ready,
    output mts_pkg::t_out                  o_out,
    input  logic                           i_cfg_we,
    input  logic [mts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mts_pkg::ADDR_W-1:0]     i_cfg_data
);

    mts_pkg::t_cfg   r_cfg;
    mts_pkg::t_state r_state;
    mts_pkg::t_state n_state;
    mts_pkg::t_in    r_in;
    logic            r_in_valid;
    mts_pkg::t_out   r_out;
    mts_pkg::t_out   n_out;
    logic            r_out_valid;
    logic            w_fire;

    assign w_fire  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_fire;
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_address <= mts_pkg::BASE_RESET;
            r_cfg.total_words  <= mts_pkg::TOTAL_RESET;
            r_cfg.chunk_words  <= mts_pkg::CHUNK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mts_pkg::CFG_BASE:  r_cfg.base_address <= i_cfg_data;
                mts_pkg::CFG_TOTAL: r_cfg.total_words  <= i_cfg_data[mts_pkg::TOTAL_W-1:0];
                mts_pkg::CFG_CHUNK: r_cfg.chunk_words  <= i_cfg_data[mts_pkg::CHUNK_W-1:0];
                default: ;
            endcase
        end
    end

    mts_step #(
        .WALK_WORDS(WALK_WORDS)
    ) u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_item  (r_in),
        .o_state (n_state),
        .o_result(n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase            <= mts_pkg::PH_AA;
            r_state.walk_zeros       <= 1'b0;
            r_state.verify_pass      <= 1'b0;
            r_state.word_index       <= '0;
            r_state.chunk_offset     <= '0;
            r_state.mismatch_total   <= '0;
            r_state.pending_expected <= '0;
            r_state.pending_read     <= 1'b0;
            r_in_valid               <= 1'b0;
            r_out_valid              <= 1'b0;
        end else begin
            if (w_fire) begin
                r_state <= n_state;
            end
            // input register: refill on accept, drain when the step fires
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_in;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    a_done_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.test_done) |-> !o_out.req_valid)
        else $error("request issued after test done");

    a_write_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out.req_write || o_out.req_data != '0)) |-> o_out.req_valid)
        else $error("write fields set without a request");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.command == mts_pkg::CMD_STEP)
        |=> (r_state.mismatch_total >= $past(r_state.mismatch_total)))
        else $error("mismatch count went down without restart");

    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed step produced no result");

endmodule

@@ src/mts_step.sv @@
module mts_step #(
    parameter int WALK_WORDS = mts_pkg::WALK_WORDS_DEF
) (
    input  mts_pkg::t_state i_state,
    input  mts_pkg::t_cfg   i_cfg,
    input  mts_pkg::t_in    i_item,
    output mts_pkg::t_state o_state,
    output mts_pkg::t_out   o_result
);

    localparam logic [mts_pkg::CHUNK_W-1:0] WALK_N = mts_pkg::CHUNK_W'(WALK_WORDS);

    logic [mts_pkg::CHUNK_W-1:0] w_cw;
    logic                        w_active;
    logic [mts_pkg::TOTAL_W-1:0] w_left;
    logic [mts_pkg::CHUNK_W-1:0] w_count;
    logic [mts_pkg::CHUNK_W-1:0] w_len;
    logic [mts_pkg::CHUNK_W:0]   w_idx_inc;
    logic                        w_last;
    logic [mts_pkg::TOTAL_W:0]   w_word;
    logic [mts_pkg::ADDR_W-1:0]  w_addr;
    logic [mts_pkg::DATA_W-1:0]  w_bit;
    logic [mts_pkg::DATA_W-1:0]  w_pattern;
    logic                        w_miss;

    // a zero chunk size behaves as one word
    assign w_cw     = (i_cfg.chunk_words == '0) ? mts_pkg::CHUNK_W'(1) : i_cfg.chunk_words;
    assign w_active = i_state.chunk_offset < i_cfg.total_words;
    assign w_left   = i_cfg.total_words - i_state.chunk_offset;
    assign w_count  = ({{(mts_pkg::TOTAL_W-mts_pkg::CHUNK_W){1'b0}}, w_cw} < w_left)
                      ? w_cw : w_left[mts_pkg::CHUNK_W-1:0];
    assign w_len    = (i_state.phase == mts_pkg::PH_WALK && w_count > WALK_N) ? WALK_N : w_count;
    assign w_idx_inc = {1'b0, i_state.word_index} + (mts_pkg::CHUNK_W+1)'(1);
    assign w_last    = !(w_idx_inc < {1'b0, w_len});

    assign w_word = {1'b0, i_state.chunk_offset}
                  + {{(mts_pkg::TOTAL_W+1-mts_pkg::CHUNK_W){1'b0}}, i_state.word_index};
    assign w_addr = {i_cfg.base_address[mts_pkg::ADDR_W-1:2], 2'b00}
                  + {{(mts_pkg::ADDR_W-mts_pkg::TOTAL_W-3){1'b0}}, w_word, 2'b00};
    assign w_bit  = mts_pkg::DATA_W'(1) << i_state.word_index[4:0];

    always_comb begin
        case (i_state.phase)
            mts_pkg::PH_AA:   w_pattern = mts_pkg::PAT_AA;
            mts_pkg::PH_55:   w_pattern = mts_pkg::PAT_55;
            mts_pkg::PH_FF:   w_pattern = mts_pkg::PAT_FF;
            mts_pkg::PH_00:   w_pattern = mts_pkg::PAT_00;
            mts_pkg::PH_WALK: w_pattern = i_state.walk_zeros ? ~w_bit : w_bit;
            default:          w_pattern = w_addr;
        endcase
    end

    assign w_miss = (i_item.read_data != i_state.pending_expected)
                 && (i_state.mismatch_total != '1);

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_item.command == mts_pkg::CMD_RESTART) begin
            o_state.phase            = mts_pkg::PH_AA;
            o_state.walk_zeros       = 1'b0;
            o_state.verify_pass      = 1'b0;
            o_state.word_index       = '0;
            o_state.chunk_offset     = '0;
            o_state.mismatch_total   = '0;
            o_state.pending_expected = '0;
            o_state.pending_read     = 1'b0;
        end else begin
            // check the read issued on the previous beat
            if (i_state.pending_read) begin
                if (w_miss) begin
                    o_state.mismatch_total = i_state.mismatch_total + mts_pkg::DATA_W'(1);
                end
                o_state.pending_read     = 1'b0;
                o_state.pending_expected = '0;
            end
            if (w_active) begin
                o_result.req_valid   = 1'b1;
                o_result.req_address = w_addr;
                if (!i_state.verify_pass) begin
                    o_result.req_write = 1'b1;
                    o_result.req_data  = w_pattern;
                end else begin
                    o_state.pending_read     = 1'b1;
                    o_state.pending_expected = w_pattern;
                end
                if (!w_last) begin
                    o_state.word_index = w_idx_inc[mts_pkg::CHUNK_W-1:0];
                end else begin
                    o_state.word_index = '0;
                    if (!i_state.verify_pass) begin
                        o_state.verify_pass = 1'b1;
                    end else begin
                        o_state.verify_pass = 1'b0;
                        if (i_state.phase == mts_pkg::PH_WALK && !i_state.walk_zeros) begin
                            o_state.walk_zeros = 1'b1;
                        end else begin
                            o_state.walk_zeros = 1'b0;
                            case (i_state.phase)
                                mts_pkg::PH_AA:   o_state.phase = mts_pkg::PH_55;
                                mts_pkg::PH_55:   o_state.phase = mts_pkg::PH_FF;
                                mts_pkg::PH_FF:   o_state.phase = mts_pkg::PH_00;
                                mts_pkg::PH_00:   o_state.phase = mts_pkg::PH_WALK;
                                mts_pkg::PH_WALK: o_state.phase = mts_pkg::PH_ADDR;
                                default: begin
                                    // chunk finished all phases: move on
                                    o_state.phase        = mts_pkg::PH_AA;
                                    o_state.chunk_offset = i_state.chunk_offset
                                        + {{(mts_pkg::TOTAL_W-mts_pkg::CHUNK_W){1'b0}}, w_count};
                                end
                            endcase
                        end
                    end
                end
            end
        end
        o_result.error_count = o_state.mismatch_total;
        o_result.words_done  = o_state.chunk_offset;
        o_result.test_done   = (o_state.chunk_offset >= i_cfg.total_words)
                            && !o_state.pending_read;
    end

endmodule

@@ bench/tb_memory_test_sequencer.sv @@
module tb_memory_test_sequencer;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic                          o_ready;
    mts_pkg::t_in                  i_in        = '0;
    logic                          o_valid;
    logic                          i_ready     = 1'b0;
    mts_pkg::t_out                 o_out;
    logic                          i_cfg_we    = 1'b0;
    logic [mts_pkg::CFG_IDX_W-1:0] i_cfg_index = mts_pkg::CFG_BASE;
    logic [mts_pkg::ADDR_W-1:0]    i_cfg_data  = '0;

    // golden copy of the sequencer and its registers
    mts_pkg::t_cfg   seq_cfg;
    mts_pkg::t_state seq_st;
    mts_pkg::t_out   step_results_q[$];

    int            fail_cnt  = 0;
    int            src_idle  = 0;
    int            sink_idle = 0;
    int            hold_left = 0;
    logic          hold_tog  = 1'b0;
    logic          hold_seen = 1'b0;
    mts_pkg::t_out want_out;

    always #4 i_clk = ~i_clk;

    memory_test_sequencer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic logic [31:0] pattern_of(logic [31:0] addr);
        logic [31:0] one_hot;
        one_hot = 32'd1 << seq_st.word_index[4:0];
        case (seq_st.phase)
            mts_pkg::PH_AA:   return mts_pkg::PAT_AA;
            mts_pkg::PH_55:   return mts_pkg::PAT_55;
            mts_pkg::PH_FF:   return mts_pkg::PAT_FF;
            mts_pkg::PH_00:   return mts_pkg::PAT_00;
            mts_pkg::PH_WALK: return seq_st.walk_zeros ? ~one_hot : one_hot;
            default: return addr;
        endcase
    endfunction

    function automatic mts_pkg::t_out predict_step(mts_pkg::t_in beat);
        mts_pkg::t_out r;
        logic [31:0]   cw;
        logic [31:0]   left;
        logic [31:0]   cnt;
        logic [31:0]   pass_len;
        logic [31:0]   addr;
        r = '0;
        if (beat.command == mts_pkg::CMD_RESTART) begin
            seq_st = '0;
        end else begin
            if (seq_st.pending_read) begin
                if (beat.read_data != seq_st.pending_expected && seq_st.mismatch_total != '1)
                    seq_st.mismatch_total++;
                seq_st.pending_read     = 1'b0;
                seq_st.pending_expected = '0;
            end
            if (seq_st.chunk_offset < seq_cfg.total_words) begin
                cw       = (seq_cfg.chunk_words == '0) ? 32'd1 : 32'(seq_cfg.chunk_words);
                left     = 32'(seq_cfg.total_words) - 32'(seq_st.chunk_offset);
                cnt      = (cw < left) ? cw : left;
                pass_len = cnt;
                if (seq_st.phase == mts_pkg::PH_WALK && pass_len > mts_pkg::WALK_WORDS_DEF)
                    pass_len = mts_pkg::WALK_WORDS_DEF;
                addr = {seq_cfg.base_address[31:2], 2'b00}
                     + ((32'(seq_st.chunk_offset) + 32'(seq_st.word_index)) << 2);
                r.req_valid   = 1'b1;
                r.req_address = addr;
                if (!seq_st.verify_pass) begin
                    r.req_write = 1'b1;
                    r.req_data  = pattern_of(addr);
                end else begin
                    seq_st.pending_read     = 1'b1;
                    seq_st.pending_expected = pattern_of(addr);
                end
                if (32'(seq_st.word_index) + 32'd1 < pass_len) begin
                    seq_st.word_index++;
                end else begin
                    seq_st.word_index = '0;
                    if (!seq_st.verify_pass) begin
                        seq_st.verify_pass = 1'b1;
                    end else begin
                        seq_st.verify_pass = 1'b0;
                        if (seq_st.phase == mts_pkg::PH_WALK && !seq_st.walk_zeros) begin
                            seq_st.walk_zeros = 1'b1;
                        end else begin
                            seq_st.walk_zeros = 1'b0;
                            if (seq_st.phase == mts_pkg::PH_ADDR) begin
                                seq_st.phase        = mts_pkg::PH_AA;
                                seq_st.chunk_offset = seq_st.chunk_offset
                                                    + cnt[mts_pkg::TOTAL_W-1:0];
                            end else begin
                                seq_st.phase = mts_pkg::t_phase'(seq_st.phase + 3'd1);
                            end
                        end
                    end
                end
            end
        end
        r.error_count = seq_st.mismatch_total;
        r.words_done  = seq_st.chunk_offset;
        r.test_done   = (seq_st.chunk_offset >= seq_cfg.total_words) && !seq_st.pending_read;
        return r;
    endfunction

    function automatic logic region_done();
        return (seq_st.chunk_offset >= seq_cfg.total_words) && !seq_st.pending_read;
    endfunction

    function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (step_results_q.size() == 0) begin
                $display("%0t: unexpected result beat, expected none actual %h", $time, o_out);
                fail_cnt++;
            end else begin
                want_out = step_results_q.pop_front();
                cmp_field("req_valid",   32'(want_out.req_valid),   32'(o_out.req_valid));
                cmp_field("req_write",   32'(want_out.req_write),   32'(o_out.req_write));
                cmp_field("req_address", want_out.req_address,      o_out.req_address);
                cmp_field("req_data",    want_out.req_data,         o_out.req_data);
                cmp_field("error_count", want_out.error_count,      o_out.error_count);
                cmp_field("words_done",  32'(want_out.words_done),  32'(o_out.words_done));
                cmp_field("test_done",   32'(want_out.test_done),   32'(o_out.test_done));
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_left <= 200;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= sink_idle);
        end
    end

    task automatic send_beat(mts_pkg::t_in beat);
        while ($urandom_range(99) < src_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= beat;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        step_results_q.push_back(predict_step(beat));
    endtask

    // advance one step; feed back the right read data unless corrupted
    task automatic step(int bad_pct);
        mts_pkg::t_in beat;
        beat.command = mts_pkg::CMD_STEP;
        if (seq_st.pending_read) begin
            beat.read_data = seq_st.pending_expected;
            if ($urandom_range(99) < bad_pct)
                beat.read_data ^= $urandom() | (32'd1 << $urandom_range(31));
        end else begin
            beat.read_data = $urandom();
        end
        send_beat(beat);
    endtask

    task automatic restart();
        mts_pkg::t_in beat;
        beat.command   = mts_pkg::CMD_RESTART;
        beat.read_data = $urandom();
        send_beat(beat);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (step_results_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [mts_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            mts_pkg::CFG_BASE:  seq_cfg.base_address = data;
            mts_pkg::CFG_TOTAL: seq_cfg.total_words  = data[mts_pkg::TOTAL_W-1:0];
            mts_pkg::CFG_CHUNK: seq_cfg.chunk_words  = data[mts_pkg::CHUNK_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_defaults();
        step(0);
        step(0);
        restart();
        step(0);
    endtask

    // one-word region, zero chunk size: every phase on a single word
    task automatic test_single_word();
        drain();
        write_reg(mts_pkg::CFG_BASE, 32'h2000_0003);
        write_reg(mts_pkg::CFG_TOTAL, 32'd1);
        write_reg(mts_pkg::CFG_CHUNK, 32'd0);
        restart();
        repeat (14) step(30);
        step(100);
        step(0);
    endtask

    task automatic test_extremes();
        drain();
        write_reg(mts_pkg::CFG_BASE, 32'hFFFF_FFFF);
        write_reg(mts_pkg::CFG_TOTAL, 32'hFFFF_FFFF);
        write_reg(mts_pkg::CFG_CHUNK, 32'hFFFF_FFFF);
        restart();
        step(0);
        step(0);
    endtask

    task automatic test_empty_region();
        drain();
        write_reg(mts_pkg::CFG_TOTAL, 32'd0);
        step(0);
        restart();
    endtask

    // shrink the chunk below the current word index, then the region to zero words
    task automatic test_mid_pass_change();
        drain();
        write_reg(mts_pkg::CFG_BASE, 32'h0000_0000);
        write_reg(mts_pkg::CFG_TOTAL, 32'd40);
        write_reg(mts_pkg::CFG_CHUNK, 32'd20);
        restart();
        repeat (5) step(0);
        drain();
        write_reg(mts_pkg::CFG_CHUNK, 32'd2);
        repeat (2) step(0);
        drain();
        write_reg(mts_pkg::CFG_TOTAL, 32'd0);
        step(0);
    endtask

    task automatic test_backpressure();
        drain();
        write_reg(mts_pkg::CFG_BASE, $urandom());
        write_reg(mts_pkg::CFG_TOTAL, 32'd30);
        write_reg(mts_pkg::CFG_CHUNK, 32'd30);
        restart();
        hold_tog <= ~hold_tog;
        repeat (40) step(5);
        drain();
    endtask

    task automatic test_random(int n_items);
        int          sent;
        int          run_len;
        int          steps;
        int          pick;
        logic [31:0] tot;
        logic [31:0] chk;
        sent = 0;
        while (sent < n_items) begin
            drain();
            if ($urandom_range(19) == 0)
                tot = 32'd0;
            else if ($urandom_range(9) == 0)
                tot = $urandom_range(90, 41);
            else
                tot = $urandom_range(40, 1);
            case ($urandom_range(7))
                0:       chk = 32'd0;
                1:       chk = $urandom_range(131071, 1);
                2:       chk = tot;
                default: chk = $urandom_range(tot + 1, 1);
            endcase
            if ($urandom_range(3) == 0)
                write_reg(mts_pkg::CFG_BASE, 32'hFFFF_FF00 | $urandom_range(255));
            else
                write_reg(mts_pkg::CFG_BASE, $urandom());
            write_reg(mts_pkg::CFG_TOTAL, tot);
            write_reg(mts_pkg::CFG_CHUNK, chk);
            restart();
            sent++;
            run_len = $urandom_range(600, 40);
            steps   = 0;
            while (!region_done() && steps < run_len && sent < n_items) begin
                pick = $urandom_range(999);
                if (pick < 4) begin
                    restart();
                end else if (pick < 8) begin
                    drain();
                    if ($urandom_range(1))
                        write_reg(mts_pkg::CFG_CHUNK, $urandom_range(8, 1));
                    else
                        write_reg(mts_pkg::CFG_TOTAL, $urandom_range(60, 0));
                end else begin
                    step(3);
                end
                steps++;
                sent++;
            end
            // extra steps after the run; they issue no request only if the region is finished
            repeat ($urandom_range(2)) step(0);
        end
    endtask

    initial begin
        seq_st    = '0;
        seq_cfg   = {mts_pkg::BASE_RESET, mts_pkg::TOTAL_RESET, mts_pkg::CHUNK_RESET};
        src_idle  = 8;
        sink_idle = 76;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_single_word();
        test_extremes();
        test_empty_region();
        test_mid_pass_change();
        test_backpressure();
        test_random(600);
        src_idle  = 76;
        sink_idle = 8;
        test_random(550);
        src_idle  = 0;
        sink_idle = 0;
        test_random(550);
        drain();
        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
